// ===== src/complex_arithmetic_unit_defines.svh =====
// Assertion macros shared by the complex arithmetic unit RTL
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define CAU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/cau_pkg.sv =====
// Types, constants and helper functions of the complex arithmetic unit
package cau_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * WORD_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int DSUM_W = WORD_W + 1;
	localparam int NUM_W  = PROD_W + FRAC_W;
	localparam int NHI_W  = NUM_W - WORD_W;
	localparam int DEN_W  = PROD_W;
	localparam int REM_W  = DEN_W;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [DSUM_W-1:0] dsum_t;

	typedef enum logic [3:0] {
		ACT_ADD  = 4'd0,
		ACT_ADDS = 4'd1,
		ACT_SUB  = 4'd2,
		ACT_SUBS = 4'd3,
		ACT_MUL  = 4'd4,
		ACT_MULS = 4'd5,
		ACT_DIV  = 4'd6,
		ACT_DIVS = 4'd7,
		ACT_CONJ = 4'd8,
		ACT_NEG  = 4'd9,
		ACT_NORM = 4'd10
	} act_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	// one lane of the divider: partial remainder and numerator/quotient shift word
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [WORD_W-1:0] nq;
	} dlane_t;

	// information that rides along the divider
	typedef struct packed {
		logic  is_div;
		logic  dz;
		logic  neg_re;
		logic  neg_im;
		logic  ovf_re;
		logic  ovf_im;
		logic  sat;
		word_t res_re;
		word_t res_im;
	} side_t;

	typedef struct packed {
		logic  sat;
		word_t val;
	} sat_t;

	// full-width signed product of two words
	function automatic prod_t mul_w(input word_t x, input word_t y);
		prod_t xe;
		prod_t ye;
		xe = prod_t'(x);
		ye = prod_t'(y);
		return xe * ye;
	endfunction

	// clamp a wide signed value to the word range
	function automatic sat_t sat_word(input sum_t v);
		sum_t hi;
		sum_t lo;
		sat_t r;
		hi = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
		lo = {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
		r.sat = 1'b0;
		r.val = v[WORD_W-1:0];
		if (v > hi) begin
			r.sat = 1'b1;
			r.val = hi[WORD_W-1:0];
		end else if (v < lo) begin
			r.sat = 1'b1;
			r.val = lo[WORD_W-1:0];
		end
		return r;
	endfunction

	// one restoring division step: shift in a numerator bit, subtract if it fits
	function automatic dlane_t div_step(input dlane_t x, input logic [DEN_W-1:0] d);
		logic [REM_W:0] t;
		logic           qb;
		dlane_t         r;
		t  = {x.rem, x.nq[WORD_W-1]};
		qb = 1'b0;
		if (t >= {1'b0, d}) begin
			t  = t - {1'b0, d};
			qb = 1'b1;
		end
		r.rem = t[REM_W-1:0];
		r.nq  = {x.nq[WORD_W-2:0], qb};
		return r;
	endfunction

endpackage

// ===== src/cau_if.sv =====
// Handshake channels of the complex arithmetic unit: operand item and result item
interface cau_in_if;
	logic              valid;
	logic              ready;
	logic [3:0]        action;
	logic signed [31:0] a_re;
	logic signed [31:0] a_im;
	logic signed [31:0] b_re;
	logic signed [31:0] b_im;

	modport source (output valid, output action, output a_re, output a_im,
		output b_re, output b_im, input ready);
	modport sink (input valid, input action, input a_re, input a_im,
		input b_re, input b_im, output ready);
endinterface

interface cau_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] res_re;
	logic signed [31:0] res_im;
	logic [1:0]         status;

	modport source (output valid, output res_re, output res_im, output status,
		input ready);
	modport sink (input valid, input res_re, input res_im, input status,
		output ready);
endinterface

// ===== src/cau_div.sv =====
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage
`include "complex_arithmetic_unit_defines.svh"

module cau_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  cau_pkg::dlane_t         in_re,
	input  cau_pkg::dlane_t         in_im,
	input  logic [cau_pkg::DEN_W-1:0] in_den,
	input  cau_pkg::side_t          in_side,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [cau_pkg::WORD_W-1:0] out_q_re,
	output logic [cau_pkg::WORD_W-1:0] out_q_im,
	output cau_pkg::side_t          out_side
);
	import cau_pkg::*;

	localparam int STAGES = WORD_W;

	logic               v_s   [STAGES];
	logic               en    [STAGES];
	dlane_t             re_s  [STAGES];
	dlane_t             im_s  [STAGES];
	logic [DEN_W-1:0]   den_s [STAGES];
	side_t              side_s[STAGES];

	// advance a stage when it is empty or the next one advances
	always_comb begin
		en[STAGES-1] = !v_s[STAGES-1] || out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= in_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (en[k] && in_valid) begin
					re_s[k]   <= div_step(in_re, in_den);
					im_s[k]   <= div_step(in_im, in_den);
					den_s[k]  <= in_den;
					side_s[k] <= in_side;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en[k] && v_s[k-1]) begin
					re_s[k]   <= div_step(re_s[k-1], den_s[k-1]);
					im_s[k]   <= div_step(im_s[k-1], den_s[k-1]);
					den_s[k]  <= den_s[k-1];
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign out_q_re  = re_s[STAGES-1].nq;
	assign out_q_im  = im_s[STAGES-1].nq;
	assign out_side  = side_s[STAGES-1];

	`CAU_ASSERT_SAME(a_rem_below_den, clk, arst_n,
		v_s[STAGES-1] && side_s[STAGES-1].is_div && !side_s[STAGES-1].dz && !side_s[STAGES-1].ovf_re,
		re_s[STAGES-1].rem < den_s[STAGES-1], "divider remainder not below divisor")
	`CAU_ASSERT_SAME(a_empty_takes, clk, arst_n, !v_s[0], in_ready,
		"empty first stage refuses an item")
	`CAU_ASSERT_NEXT(a_take_fills, clk, arst_n, in_valid && in_ready, v_s[0],
		"accepted item missing from first stage")

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// Complex arithmetic unit: pipelined add, subtract, multiply, divide, conjugate,
// negate and squared magnitude on signed Q16.16 complex operands. A new item may
// enter in every cycle while the output is not held by back-pressure; every item
// passes through the 32-stage restoring divider, one quotient bit per stage, so
// results leave in order. Any stage that is empty lets the stages behind it move
// up while a result waits on the output.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit (
	input  logic      clk,
	input  logic      arst_n,
	cau_in_if.sink    cmd,
	cau_out_if.source rsp
);
	import cau_pkg::*;

	// stage enables and valid bits
	logic en1, en2, en3, en_o;
	logic v_s1, v_s2, v_s3, v_o_q;

	// stage 1: products and direct sums
	act_t  act_in;
	dsum_t dre_c, dim_c;
	word_t x4_c, x5_c;
	act_t  act_s1;
	dsum_t dre_s1, dim_s1;
	prod_t m0_s1, m1_s1, m2_s1, m3_s1, m4_s1, m5_s1;
	word_t ar_s1, ai_s1, br_s1;

	// stage 2: sums of products and divisor
	sum_t             sre_c, sim_c;
	logic [DEN_W-1:0] den_c;
	dsum_t            bre_c;
	act_t             act_s2;
	dsum_t            dre_s2, dim_s2;
	sum_t             sre_s2, sim_s2;
	logic [DEN_W-1:0] den_s2;
	logic             dneg_s2;

	// stage 3: shift and clamp, divider setup
	sum_t             sh_re, sh_im, neg_re_c, neg_im_c;
	logic [PROD_W-1:0] mag_re, mag_im;
	logic [NUM_W-1:0] num_re, num_im;
	logic [NHI_W-1:0] nhi_re, nhi_im;
	sat_t             sr_c, si_c;
	side_t            side_c, side_s3;
	dlane_t           lre_c, lim_c, lre_s3, lim_s3;
	logic [DEN_W-1:0] den_s3;

	// divider and output
	logic              div_ready, div_valid;
	logic [WORD_W-1:0] q_re, q_im;
	side_t             dside;
	sum_t              qe_re, qe_im;
	sat_t              fr_c, fi_c;
	word_t             ore_c, oim_c;
	status_t           ost_c;
	word_t             res_re_q, res_im_q;
	status_t           status_q;

	// move up when the stage is empty or the next one moves
	assign en_o      = !v_o_q || rsp.ready;
	assign en3       = !v_s3 || div_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign cmd.ready = en1;

	assign act_in = act_t'(cmd.action);

	// decode the sum-type actions
	always_comb begin
		dre_c = '0;
		dim_c = '0;
		unique case (act_in)
			ACT_ADD: begin
				dre_c = dsum_t'(cmd.a_re) + dsum_t'(cmd.b_re);
				dim_c = dsum_t'(cmd.a_im) + dsum_t'(cmd.b_im);
			end
			ACT_ADDS: begin
				dre_c = dsum_t'(cmd.a_re) + dsum_t'(cmd.b_re);
				dim_c = dsum_t'(cmd.a_im);
			end
			ACT_SUB: begin
				dre_c = dsum_t'(cmd.a_re) - dsum_t'(cmd.b_re);
				dim_c = dsum_t'(cmd.a_im) - dsum_t'(cmd.b_im);
			end
			ACT_SUBS: begin
				dre_c = dsum_t'(cmd.a_re) - dsum_t'(cmd.b_re);
				dim_c = dsum_t'(cmd.a_im);
			end
			ACT_CONJ: begin
				dre_c = dsum_t'(cmd.a_re);
				dim_c = -dsum_t'(cmd.a_im);
			end
			ACT_NEG: begin
				dre_c = -dsum_t'(cmd.a_re);
				dim_c = -dsum_t'(cmd.a_im);
			end
			default: begin
				dre_c = '0;
				dim_c = '0;
			end
		endcase
	end

	// squares of A for norm, of B for the divisor
	assign x4_c = (act_in == ACT_NORM) ? cmd.a_re : cmd.b_re;
	assign x5_c = (act_in == ACT_NORM) ? cmd.a_im : cmd.b_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= cmd.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 1 registers
	always_ff @(posedge clk) begin
		if (en1 && cmd.valid) begin
			act_s1 <= act_in;
			dre_s1 <= dre_c;
			dim_s1 <= dim_c;
			m0_s1  <= mul_w(cmd.a_re, cmd.b_re);
			m1_s1  <= mul_w(cmd.a_im, cmd.b_im);
			m2_s1  <= mul_w(cmd.a_re, cmd.b_im);
			m3_s1  <= mul_w(cmd.a_im, cmd.b_re);
			m4_s1  <= mul_w(x4_c, x4_c);
			m5_s1  <= mul_w(x5_c, x5_c);
			ar_s1  <= cmd.a_re;
			ai_s1  <= cmd.a_im;
			br_s1  <= cmd.b_re;
		end
	end

	// combine products per action
	assign bre_c = br_s1[WORD_W-1] ? -dsum_t'(br_s1) : dsum_t'(br_s1);

	always_comb begin
		sre_c = '0;
		sim_c = '0;
		den_c = $unsigned(m4_s1) + $unsigned(m5_s1);
		case (act_s1)
			ACT_MUL: begin
				sre_c = sum_t'(m0_s1) - sum_t'(m1_s1);
				sim_c = sum_t'(m2_s1) + sum_t'(m3_s1);
			end
			ACT_MULS: begin
				sre_c = sum_t'(m0_s1);
				sim_c = sum_t'(m3_s1);
			end
			ACT_DIV: begin
				sre_c = sum_t'(m0_s1) + sum_t'(m1_s1);
				sim_c = sum_t'(m3_s1) - sum_t'(m2_s1);
			end
			ACT_DIVS: begin
				sre_c = sum_t'(ar_s1);
				sim_c = sum_t'(ai_s1);
				den_c = DEN_W'(bre_c[WORD_W-1:0]);
			end
			ACT_NORM: begin
				sre_c = sum_t'(m4_s1) + sum_t'(m5_s1);
				sim_c = '0;
			end
			default: begin
				sre_c = '0;
				sim_c = '0;
			end
		endcase
	end

	// stage 2 registers
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			act_s2  <= act_s1;
			dre_s2  <= dre_s1;
			dim_s2  <= dim_s1;
			sre_s2  <= sre_c;
			sim_s2  <= sim_c;
			den_s2  <= den_c;
			dneg_s2 <= (act_s1 == ACT_DIVS) && br_s1[WORD_W-1];
		end
	end

	// shift products down, take magnitudes for the divider
	assign sh_re    = sre_s2 >>> FRAC_W;
	assign sh_im    = sim_s2 >>> FRAC_W;
	assign neg_re_c = -sre_s2;
	assign neg_im_c = -sim_s2;
	assign mag_re   = sre_s2[SUM_W-1] ? neg_re_c[PROD_W-1:0] : sre_s2[PROD_W-1:0];
	assign mag_im   = sim_s2[SUM_W-1] ? neg_im_c[PROD_W-1:0] : sim_s2[PROD_W-1:0];
	assign num_re   = {mag_re, {FRAC_W{1'b0}}};
	assign num_im   = {mag_im, {FRAC_W{1'b0}}};
	assign nhi_re   = num_re[NUM_W-1 -: NHI_W];
	assign nhi_im   = num_im[NUM_W-1 -: NHI_W];

	always_comb begin
		sr_c = '0;
		si_c = '0;
		case (act_s2)
			ACT_MUL, ACT_MULS, ACT_NORM: begin
				sr_c = sat_word(sh_re);
				si_c = sat_word(sh_im);
			end
			ACT_ADD, ACT_ADDS, ACT_SUB, ACT_SUBS, ACT_CONJ, ACT_NEG: begin
				sr_c = sat_word(sum_t'(dre_s2));
				si_c = sat_word(sum_t'(dim_s2));
			end
			default: begin
				sr_c = '0;
				si_c = '0;
			end
		endcase
	end

	// quotient does not fit the word when the upper numerator reaches the divisor
	always_comb begin
		side_c.is_div = (act_s2 == ACT_DIV) || (act_s2 == ACT_DIVS);
		side_c.dz     = (den_s2 == '0);
		side_c.neg_re = sre_s2[SUM_W-1] ^ dneg_s2;
		side_c.neg_im = sim_s2[SUM_W-1] ^ dneg_s2;
		side_c.ovf_re = DEN_W'(nhi_re) >= den_s2;
		side_c.ovf_im = DEN_W'(nhi_im) >= den_s2;
		side_c.sat    = sr_c.sat || si_c.sat;
		side_c.res_re = sr_c.val;
		side_c.res_im = si_c.val;
		lre_c.rem     = side_c.ovf_re ? '0 : REM_W'(nhi_re);
		lre_c.nq      = num_re[WORD_W-1:0];
		lim_c.rem     = side_c.ovf_im ? '0 : REM_W'(nhi_im);
		lim_c.nq      = num_im[WORD_W-1:0];
	end

	// stage 3 registers
	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			side_s3 <= side_c;
			lre_s3  <= lre_c;
			lim_s3  <= lim_c;
			den_s3  <= den_s2;
		end
	end

	cau_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (div_ready),
		.in_re     (lre_s3),
		.in_im     (lim_s3),
		.in_den    (den_s3),
		.in_side   (side_s3),
		.out_valid (div_valid),
		.out_ready (en_o),
		.out_q_re  (q_re),
		.out_q_im  (q_im),
		.out_side  (dside)
	);

	// sign and clamp quotients; an oversize quotient is pushed past the word range
	always_comb begin
		qe_re = dside.ovf_re ? (sum_t'(1) <<< WORD_W) : sum_t'(q_re);
		qe_im = dside.ovf_im ? (sum_t'(1) <<< WORD_W) : sum_t'(q_im);
		if (dside.neg_re) qe_re = -qe_re;
		if (dside.neg_im) qe_im = -qe_im;
		fr_c = sat_word(qe_re);
		fi_c = sat_word(qe_im);
		if (dside.is_div) begin
			if (dside.dz) begin
				ore_c = '0;
				oim_c = '0;
				ost_c = ST_DIV0;
			end else begin
				ore_c = fr_c.val;
				oim_c = fi_c.val;
				ost_c = (fr_c.sat || fi_c.sat) ? ST_SAT : ST_OK;
			end
		end else begin
			ore_c = dside.res_re;
			oim_c = dside.res_im;
			ost_c = dside.sat ? ST_SAT : ST_OK;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o_q <= 1'b0;
		end else if (en_o) begin
			v_o_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && div_valid) begin
			res_re_q <= ore_c;
			res_im_q <= oim_c;
			status_q <= ost_c;
		end
	end

	assign rsp.valid  = v_o_q;
	assign rsp.res_re = res_re_q;
	assign rsp.res_im = res_im_q;
	assign rsp.status = status_q;

	`CAU_ASSERT_SAME(a_div0_zero, clk, arst_n, rsp.valid && (rsp.status == ST_DIV0),
		(rsp.res_re == '0) && (rsp.res_im == '0), "division by zero gave a nonzero result")
	`CAU_ASSERT_SAME(a_status_code, clk, arst_n, rsp.valid,
		(rsp.status == ST_OK) || (rsp.status == ST_SAT) || (rsp.status == ST_DIV0),
		"unknown status code")
	`CAU_ASSERT_NEXT(a_take_fills, clk, arst_n, cmd.valid && cmd.ready, v_s1,
		"accepted item missing from first stage")
	`CAU_ASSERT_NEXT(a_out_holds, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid,
		"waiting result dropped")

endmodule

// ===== verif/complex_arithmetic_unit_tb.sv =====
// Self-checking testbench of the complex arithmetic unit: directed and random items
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
	import cau_pkg::*;

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic [1:0]         st;
	} cplx_res_t;

	localparam int STALL_LIMIT = 2000;
	localparam int LATENCY     = 36;

	logic clk;
	logic arst_n;
	cau_in_if  cmd ();
	cau_out_if rsp ();

	cplx_res_t expected_q[$];
	int        fail_cnt;
	int        quiet_cycles;
	bit        idle_on;

	complex_arithmetic_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.rsp    (rsp.source)
	);

	// Toggle the clock every half period
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Clamp a wide signed value into the word range, flag when clamped
	function automatic logic signed [31:0] clamp_word(input logic signed [159:0] v,
		inout bit sat);
		if (v > 160'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -160'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Divide truncating toward zero
	function automatic logic signed [159:0] trunc_div(input logic signed [159:0] n,
		input logic signed [159:0] d);
		logic [159:0] q;
		q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
		return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
	endfunction

	// Compute the expected result of one operation
	function automatic cplx_res_t compute_cplx(input logic [3:0] act,
		input logic signed [31:0] ar, input logic signed [31:0] ai,
		input logic signed [31:0] br, input logic signed [31:0] bi);
		logic signed [159:0] xr, xi, yr, yi, r, i, den;
		cplx_res_t res;
		bit sat;
		xr = ar; xi = ai; yr = br; yi = bi;
		r = 0; i = 0; sat = 1'b0;
		res.st = ST_OK;
		case (act)
			ACT_ADD: begin r = xr + yr; i = xi + yi; end
			ACT_ADDS: begin r = xr + yr; i = xi; end
			ACT_SUB: begin r = xr - yr; i = xi - yi; end
			ACT_SUBS: begin r = xr - yr; i = xi; end
			ACT_MUL: begin
				r = (xr * yr - xi * yi) >>> FRAC_W;
				i = (xr * yi + xi * yr) >>> FRAC_W;
			end
			ACT_MULS: begin r = (xr * yr) >>> FRAC_W; i = (xi * yr) >>> FRAC_W; end
			ACT_DIV: begin
				den = yr * yr + yi * yi;
				if (den == 0) res.st = ST_DIV0;
				else begin
					r = trunc_div((xr * yr + xi * yi) <<< FRAC_W, den);
					i = trunc_div((xi * yr - xr * yi) <<< FRAC_W, den);
				end
			end
			ACT_DIVS: begin
				if (yr == 0) res.st = ST_DIV0;
				else begin
					r = trunc_div(xr <<< FRAC_W, yr);
					i = trunc_div(xi <<< FRAC_W, yr);
				end
			end
			ACT_CONJ: begin r = xr; i = -xi; end
			ACT_NEG: begin r = -xr; i = -xi; end
			ACT_NORM: r = (xr * xr + xi * xi) >>> FRAC_W;
			default: ;
		endcase
		res.re = clamp_word(r, sat);
		res.im = clamp_word(i, sat);
		if (res.st == ST_OK && sat) res.st = ST_SAT;
		return res;
	endfunction

	// Pick a value biased toward the edges of the word range
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return $signed(32'($urandom_range(0, 4))) - 2;
			4: return 32'sh10000;
			5: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	// Send one item and record its expected result
	task automatic send_item(input logic [3:0] act, input logic signed [31:0] ar,
		input logic signed [31:0] ai, input logic signed [31:0] br,
		input logic signed [31:0] bi);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			cmd.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd.valid  <= 1'b1;
		cmd.action <= act;
		cmd.a_re   <= ar;
		cmd.a_im   <= ai;
		cmd.b_re   <= br;
		cmd.b_im   <= bi;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		expected_q.push_back(compute_cplx(act, ar, ai, br, bi));
		@(negedge clk);
	endtask

	// Drop valid for one cycle
	task automatic drop_valid();
		cmd.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Cover the field extremes, every action and each special case
	task automatic test_directed();
		send_item(ACT_ADD, 32'sh7fffffff, 32'sh80000000, 32'sd1, -32'sd1);
		send_item(ACT_ADDS, 32'sd5, 32'sd7, 32'sd9, 32'sh7fffffff);
		send_item(ACT_SUB, 32'sh80000000, 32'sh7fffffff, 32'sd1, -32'sd1);
		send_item(ACT_SUBS, 32'sd5, 32'sd7, 32'sh80000000, 32'sd3);
		send_item(ACT_MUL, 32'sh30000, 32'sh20000, -32'sh10000, 32'sh8000);
		send_item(ACT_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
		send_item(ACT_MULS, -32'sd1, 32'sd1, 32'sd1, 32'sd0);
		send_item(ACT_DIV, 32'sh10000, 32'sh20000, 32'sh30000, -32'sh10000);
		send_item(ACT_DIV, 32'sd5, 32'sd5, 32'sd0, 32'sd0);
		send_item(ACT_DIV, 32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd1);
		send_item(ACT_DIVS, -32'sh30000, 32'sh7fffffff, 32'sh20000, 32'sd4);
		send_item(ACT_DIVS, 32'sd1, 32'sd2, 32'sd0, 32'sd9);
		send_item(ACT_DIVS, 32'sh80000000, 32'sd1, -32'sd1, 32'sd0);
		send_item(ACT_CONJ, 32'sd3, 32'sh80000000, 32'sd0, 32'sd0);
		send_item(ACT_NEG, 32'sh80000000, 32'sh7fffffff, 32'sd0, 32'sd0);
		send_item(ACT_NORM, 32'sh80000000, 32'sh80000000, 32'sd0, 32'sd0);
		send_item(ACT_NORM, 32'sh18000, -32'sh8000, 32'sd0, 32'sd0);
		send_item(4'd11, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
		send_item(4'd15, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
		drop_valid();
	endtask

	// Hold the sender until every pending result has come out
	task automatic test_drain_pause();
		drop_valid();
		while (expected_q.size() != 0) @(negedge clk);
		send_item(ACT_MUL, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		drop_valid();
	endtask

	// Random items over all action codes, with or without idling
	task automatic test_random(input int count, input bit with_idle);
		logic [3:0] act;
		idle_on = with_idle;
		repeat (count) begin
			act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
				: 4'($urandom_range(0, 10));
			send_item(act, pick_word(), pick_word(), pick_word(), pick_word());
		end
		drop_valid();
	endtask

	// Drive the receiver ready with random stall bursts
	initial begin
		int gap;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 5);
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		cplx_res_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_q.size() == 0) begin
				$error("result with no item pending: re=%0d im=%0d status=%0d",
					rsp.res_re, rsp.res_im, rsp.status);
				fail_cnt++;
			end else begin
				exp_r = expected_q.pop_front();
				if (rsp.res_re !== exp_r.re) begin
					$error("res_re expected %0d actual %0d", exp_r.re, rsp.res_re);
					fail_cnt++;
				end
				if (rsp.res_im !== exp_r.im) begin
					$error("res_im expected %0d actual %0d", exp_r.im, rsp.res_im);
					fail_cnt++;
				end
				if (rsp.status !== exp_r.st) begin
					$error("status expected %0d actual %0d", exp_r.st, rsp.status);
					fail_cnt++;
				end
			end
		end
	end

	// Count cycles with no item moving on either side
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("complex_arithmetic_unit verification failed");
			$finish;
		end
	end

	initial begin
		int wait_cnt;
		fail_cnt     = 0;
		quiet_cycles = 0;
		idle_on      = 1'b1;
		arst_n       = 1'b0;
		cmd.valid    = 1'b0;
		cmd.action   = '0;
		cmd.a_re     = '0;
		cmd.a_im     = '0;
		cmd.b_re     = '0;
		cmd.b_im     = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(900, 1'b1);
		test_drain_pause();
		test_random(600, 1'b1);
		test_random(300, 1'b0);

		// Drain outstanding results, then let the pipeline settle
		wait_cnt = 0;
		while (expected_q.size() != 0 && wait_cnt < 20 * STALL_LIMIT) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (2 * LATENCY) @(negedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d results never arrived", expected_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("complex_arithmetic_unit verification clean");
		else
			$display("complex_arithmetic_unit verification failed");
		$finish;
	end

endmodule

// ===== complex_arithmetic_unit.f =====
+incdir+src
src/cau_pkg.sv
src/cau_if.sv
src/cau_div.sv
src/complex_arithmetic_unit.sv
verif/complex_arithmetic_unit_tb.sv
